[rtl/core/psg_tone_noise_envelope_generator_macros.svh]
// assertion macros shared by the checks of the sound generator checker
`ifndef PSG_TONE_NOISE_ENVELOPE_GENERATOR_MACROS_SVH
`define PSG_TONE_NOISE_ENVELOPE_GENERATOR_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define PSG_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("psg check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define PSG_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("psg check failed");

`endif

[rtl/core/psg_pkg.sv]
// types and constants of the programmable sound generator
`timescale 1ns / 1ps
package psg_pkg;

	// bus and tick operations
	typedef enum logic [1:0] {
		OP_LATCH = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_TICK  = 2'd3
	} psg_op_t;

	// input transaction
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] bus_data;
	} psg_req_t;

	// result transaction
	typedef struct packed {
		logic [7:0] read_data;
		logic       chan_a_on;
		logic [3:0] chan_a_level;
		logic       chan_b_on;
		logic [3:0] chan_b_level;
		logic       chan_c_on;
		logic [3:0] chan_c_level;
	} psg_rsp_t;

	// classified operation held in the queue between front and back
	typedef struct packed {
		psg_op_t    op;
		logic [7:0] data;
	} psg_cmd_t;

	localparam int NUM_REGS = 16;
	localparam int NUM_CH   = 3;
	localparam int Q_DEPTH  = 2;

	localparam logic [3:0] REG_NOISE      = 4'd6;
	localparam logic [3:0] REG_MIXER      = 4'd7;
	localparam logic [3:0] REG_AMP_A      = 4'd8;
	localparam logic [3:0] REG_ENV_FINE   = 4'd11;
	localparam logic [3:0] REG_ENV_COARSE = 4'd12;
	localparam logic [3:0] REG_SHAPE      = 4'd13;

	localparam logic [7:0] LEVEL_MASK = 8'h0F;
	localparam logic [7:0] NOISE_MASK = 8'h1F;
	localparam logic [7:0] READ_NONE  = 8'hFF;
	localparam logic [3:0] MAX_LEVEL  = 4'hF;

	// envelope shape bits
	localparam int SHAPE_HOLD_BIT   = 0;
	localparam int SHAPE_ALT_BIT    = 1;
	localparam int SHAPE_ATTACK_BIT = 2;
	localparam int SHAPE_CONT_BIT   = 3;
	localparam int AMP_ENV_BIT      = 4;

endpackage

[rtl/core/psg_front.sv]
// front end: classifies bus transactions and queues them for the engine
`timescale 1ns / 1ps
module psg_front import psg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  psg_req_t req,
	output logic     cmd_valid,
	input  logic     cmd_pop,
	output psg_cmd_t cmd
);

	localparam int PW = $clog2(Q_DEPTH);

	psg_cmd_t        mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push;
	logic            pop;
	psg_cmd_t        cls;

	// classify the incoming transaction
	always_comb begin
		cls.op   = psg_op_t'(req.func);
		cls.data = req.bus_data;
	end

	assign req_stall = (count_q == (PW+1)'(Q_DEPTH));
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/psg_back.sv]
// back end: register file, tone, noise and envelope generators, result register
`timescale 1ns / 1ps
module psg_back import psg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_pop,
	input  psg_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output psg_rsp_t rsp
);

	logic [7:0]  addr_q;
	logic [7:0]  regs_q [NUM_REGS];
	logic [11:0] tone_cnt_q [NUM_CH];
	logic        tone_ph_q [NUM_CH];
	logic [5:0]  noise_cnt_q;
	logic [16:0] lfsr_q;
	logic [16:0] env_cnt_q;
	logic [3:0]  env_lvl_q;
	logic        env_rise_q;
	logic        env_park_q;
	logic [3:0]  env_shape_q;
	logic        rsp_valid_q;
	psg_rsp_t    rsp_q;

	logic [7:0]  regs_d [NUM_REGS];
	logic [11:0] tone_cnt_d [NUM_CH];
	logic        tone_ph_d [NUM_CH];
	logic [5:0]  noise_cnt_d;
	logic [16:0] lfsr_d;
	logic [16:0] env_cnt_d;
	logic [3:0]  env_lvl_d;
	logic        env_rise_d;
	logic        env_park_d;
	logic [3:0]  env_shape_d;
	psg_rsp_t    rsp_d;

	logic        can_load;
	logic        fire;
	logic        is_latch;
	logic        is_write;
	logic        is_read;
	logic        is_tick;
	logic        addr_ok;
	logic [3:0]  addr_idx;
	logic [4:0]  noise_per;
	logic [15:0] env_per;
	logic [7:0]  rd_val;
	logic        ch_on [NUM_CH];
	logic [3:0]  ch_lvl [NUM_CH];

	// handshake between queue and result register
	assign can_load  = !rsp_valid_q || !rsp_stall;
	assign fire      = cmd_valid && can_load;
	assign cmd_pop   = fire;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_latch = fire && (cmd.op == OP_LATCH);
	assign is_write = fire && (cmd.op == OP_WRITE);
	assign is_read  = fire && (cmd.op == OP_READ);
	assign is_tick  = fire && (cmd.op == OP_TICK);
	assign addr_ok  = (addr_q[7:4] == 4'd0);
	assign addr_idx = addr_q[3:0];

	// periods, zero counts as one
	always_comb begin
		noise_per = regs_q[REG_NOISE][4:0] & NOISE_MASK[4:0];
		if (noise_per == 5'd0) begin
			noise_per = 5'd1;
		end
		env_per = {regs_q[REG_ENV_COARSE], regs_q[REG_ENV_FINE]};
		if (env_per == 16'd0) begin
			env_per = 16'd1;
		end
	end

	// register file update
	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			regs_d[i] = regs_q[i];
		end
		if (is_write && addr_ok) begin
			regs_d[addr_idx] = cmd.data;
		end
	end

	// tone counters
	always_comb begin
		logic [11:0] per;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			per = {regs_q[4'(2 * ch + 1)][3:0], regs_q[4'(2 * ch)]};
			if (per == 12'd0) begin
				per = 12'd1;
			end
			tone_cnt_d[ch] = tone_cnt_q[ch];
			tone_ph_d[ch]  = tone_ph_q[ch];
			if (is_tick) begin
				if (tone_cnt_q[ch] <= 12'd1) begin
					tone_cnt_d[ch] = per;
					tone_ph_d[ch]  = !tone_ph_q[ch];
				end else begin
					tone_cnt_d[ch] = tone_cnt_q[ch] - 12'd1;
				end
			end
		end
	end

	// noise counter and shift register
	always_comb begin
		noise_cnt_d = noise_cnt_q;
		lfsr_d      = lfsr_q;
		if (is_tick) begin
			if (noise_cnt_q <= 6'd1) begin
				noise_cnt_d = {noise_per, 1'b0};
				lfsr_d      = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]};
			end else begin
				noise_cnt_d = noise_cnt_q - 6'd1;
			end
		end
	end

	// envelope counter, ramp rules and restart on shape write
	always_comb begin
		env_cnt_d   = env_cnt_q;
		env_lvl_d   = env_lvl_q;
		env_rise_d  = env_rise_q;
		env_park_d  = env_park_q;
		env_shape_d = env_shape_q;
		if (is_write && addr_ok && (addr_idx == REG_SHAPE)) begin
			env_shape_d = cmd.data[3:0];
			env_park_d  = 1'b0;
			env_rise_d  = cmd.data[SHAPE_ATTACK_BIT];
			env_lvl_d   = cmd.data[SHAPE_ATTACK_BIT] ? 4'd0 : MAX_LEVEL;
			env_cnt_d   = {env_per, 1'b0};
		end else if (is_tick) begin
			if (env_cnt_q <= 17'd1) begin
				env_cnt_d = {env_per, 1'b0};
				if (!env_park_q) begin
					if (env_rise_q && (env_lvl_q != MAX_LEVEL)) begin
						env_lvl_d = env_lvl_q + 4'd1;
					end else if (!env_rise_q && (env_lvl_q != 4'd0)) begin
						env_lvl_d = env_lvl_q - 4'd1;
					end else if (!env_shape_q[SHAPE_CONT_BIT]) begin
						env_lvl_d  = 4'd0;
						env_park_d = 1'b1;
					end else if (env_shape_q[SHAPE_HOLD_BIT]) begin
						env_park_d = 1'b1;
						if (env_shape_q[SHAPE_ALT_BIT]) begin
							env_lvl_d = env_rise_q ? 4'd0 : MAX_LEVEL;
						end
					end else if (env_shape_q[SHAPE_ALT_BIT]) begin
						env_rise_d = !env_rise_q;
					end else begin
						env_lvl_d = env_rise_q ? 4'd0 : MAX_LEVEL;
					end
				end
			end else begin
				env_cnt_d = env_cnt_q - 17'd1;
			end
		end
	end

	// result from the state after this transaction
	always_comb begin
		logic [7:0] mixer;
		logic [7:0] amp;
		mixer  = regs_d[REG_MIXER];
		rd_val = 8'd0;
		if (is_read) begin
			rd_val = addr_ok ? regs_q[addr_idx] : READ_NONE;
		end
		for (int ch = 0; ch < NUM_CH; ch++) begin
			amp        = regs_d[REG_AMP_A + 4'(ch)];
			ch_on[ch]  = (mixer[ch] | tone_ph_d[ch]) & (mixer[ch + 3] | lfsr_d[0]);
			ch_lvl[ch] = amp[AMP_ENV_BIT] ? env_lvl_d : (amp[3:0] & LEVEL_MASK[3:0]);
		end
		rsp_d.read_data    = rd_val;
		rsp_d.chan_a_on    = ch_on[0];
		rsp_d.chan_a_level = ch_lvl[0];
		rsp_d.chan_b_on    = ch_on[1];
		rsp_d.chan_b_level = ch_lvl[1];
		rsp_d.chan_c_on    = ch_on[2];
		rsp_d.chan_c_level = ch_lvl[2];
	end

	// generator and register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'd0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 8'd0;
			end
			for (int ch = 0; ch < NUM_CH; ch++) begin
				tone_cnt_q[ch] <= 12'd1;
				tone_ph_q[ch]  <= 1'b0;
			end
			noise_cnt_q <= 6'd2;
			lfsr_q      <= 17'd1;
			env_cnt_q   <= 17'd2;
			env_lvl_q   <= 4'd0;
			env_rise_q  <= 1'b0;
			env_park_q  <= 1'b0;
			env_shape_q <= 4'd0;
		end else begin
			if (is_latch) begin
				addr_q <= cmd.data;
			end
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= regs_d[i];
			end
			for (int ch = 0; ch < NUM_CH; ch++) begin
				tone_cnt_q[ch] <= tone_cnt_d[ch];
				tone_ph_q[ch]  <= tone_ph_d[ch];
			end
			noise_cnt_q <= noise_cnt_d;
			lfsr_q      <= lfsr_d;
			env_cnt_q   <= env_cnt_d;
			env_lvl_q   <= env_lvl_d;
			env_rise_q  <= env_rise_d;
			env_park_q  <= env_park_d;
			env_shape_q <= env_shape_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (can_load) begin
			rsp_valid_q <= cmd_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

[rtl/core/psg_tone_noise_envelope_generator.sv]
// top level of the three-voice tone, noise and envelope sound generator
`timescale 1ns / 1ps
// Three-voice sound generator driven by one transaction per item: latch an address,
// write or read the latched byte register, or a base tick that advances the three
// tone counters, the 17-bit noise shift register and the envelope. Every transaction
// yields exactly one result carrying the read data (zero unless reading) and, per
// channel, the mixer gate and 4-bit level after it. Throughput is one transaction
// per clock while the result is not stalled: all generators update together in the
// engine. An accepted transaction passes through the two-entry command queue and
// then the result register; the queue lets input keep flowing while a result waits
// to be taken.
module psg_tone_noise_envelope_generator import psg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  psg_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output psg_rsp_t rsp
);

	logic     cmd_valid;
	logic     cmd_pop;
	psg_cmd_t cmd;

	// classification and queue
	psg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// generators and result register
	psg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[rtl/core/psg_checker.sv]
// port-level checks for the sound generator, bound to the top level
`timescale 1ns / 1ps
`include "psg_tone_noise_envelope_generator_macros.svh"
module psg_checker import psg_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input psg_req_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input psg_rsp_t rsp
);

	// a stalled input transaction holds
	`PSG_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req))

	// a stalled result transaction holds
	`PSG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// a full queue always has a result in front of it
	`PSG_ASSERT_NEXT(a_full_has_rsp, req_stall, rsp_valid)

	// an empty result register means the queue cannot be full
	`PSG_ASSERT_NOW(a_no_stall_when_empty, !rsp_valid, !req_stall)

endmodule

bind psg_tone_noise_envelope_generator psg_checker u_psg_checker (.*);

[dv/tb_top.sv]
// self-checking testbench for the three-voice tone, noise and envelope sound generator
`timescale 1ns / 1ps
module tb_top;
	import psg_pkg::*;

	localparam int         RANDOM_ITEMS = 1550;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 10;
	localparam int         MAX_REPORTS  = 20;
	localparam logic [3:0] REG_TONE_A   = 4'd0;

	// predicts the result of every accepted transaction and holds them until they come back
	class psg_result_predictor;
		logic [7:0]  addr_latch;
		logic [7:0]  regs [NUM_REGS];
		logic [11:0] tone_cnt [NUM_CH];
		logic        tone_ph [NUM_CH];
		logic [5:0]  noise_cnt;
		logic [16:0] noise_lfsr;
		logic [16:0] env_cnt;
		logic [3:0]  env_lvl;
		logic        env_up;
		logic        env_held;
		logic [3:0]  env_shape;
		psg_rsp_t    expected_q[$];
		int          n_latch, n_write, n_read, n_tick, n_restart, n_checked, n_errors;

		// state after reset
		function new();
			addr_latch = '0;
			foreach (regs[i]) regs[i] = '0;
			foreach (tone_cnt[i]) begin
				tone_cnt[i] = 12'd1;
				tone_ph[i]  = 1'b0;
			end
			noise_cnt  = 6'd2;
			noise_lfsr = 17'd1;
			env_cnt    = 17'd2;
			env_lvl    = '0;
			env_up     = 1'b0;
			env_held   = 1'b0;
			env_shape  = '0;
		endfunction

		// periods of zero count as one
		function logic [11:0] tone_period(int ch);
			logic [11:0] p;
			p = {regs[REG_TONE_A + 2 * ch + 1][3:0], regs[REG_TONE_A + 2 * ch]};
			return (p == '0) ? 12'd1 : p;
		endfunction

		function logic [4:0] noise_period();
			logic [7:0] p;
			p = regs[REG_NOISE] & NOISE_MASK;
			return (p == '0) ? 5'd1 : p[4:0];
		endfunction

		function logic [15:0] env_period();
			logic [15:0] p;
			p = {regs[REG_ENV_COARSE], regs[REG_ENV_FINE]};
			return (p == '0) ? 16'd1 : p;
		endfunction

		// a shape write starts the envelope again from its attack end
		function void restart_envelope(logic [7:0] v);
			env_shape = v[3:0];
			env_held  = 1'b0;
			env_up    = env_shape[SHAPE_ATTACK_BIT];
			env_lvl   = env_up ? 4'd0 : MAX_LEVEL;
			env_cnt   = {env_period(), 1'b0};
		endfunction

		// one envelope step under the continue, hold and alternate rules
		function void advance_envelope();
			if (env_held)
				return;
			if (env_up && env_lvl < MAX_LEVEL) begin
				env_lvl++;
			end else if (!env_up && env_lvl > 0) begin
				env_lvl--;
			end else if (!env_shape[SHAPE_CONT_BIT]) begin
				env_lvl  = '0;
				env_held = 1'b1;
			end else if (env_shape[SHAPE_HOLD_BIT]) begin
				env_held = 1'b1;
				if (env_shape[SHAPE_ALT_BIT])
					env_lvl = env_up ? 4'd0 : MAX_LEVEL;
			end else if (env_shape[SHAPE_ALT_BIT]) begin
				env_up = !env_up;
			end else begin
				env_lvl = env_up ? 4'd0 : MAX_LEVEL;
			end
		endfunction

		// base tick: tones, noise shifter and envelope counter
		function void clock_generators();
			logic fb;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				if (tone_cnt[ch] <= 1) begin
					tone_cnt[ch] = tone_period(ch);
					tone_ph[ch]  = ~tone_ph[ch];
				end else begin
					tone_cnt[ch]--;
				end
			end
			if (noise_cnt <= 1) begin
				fb         = noise_lfsr[0] ^ noise_lfsr[3];
				noise_cnt  = {noise_period(), 1'b0};
				noise_lfsr = {fb, noise_lfsr[16:1]};
			end else begin
				noise_cnt--;
			end
			if (env_cnt <= 1) begin
				env_cnt = {env_period(), 1'b0};
				advance_envelope();
			end else begin
				env_cnt--;
			end
		endfunction

		// mixer gate of one channel
		function logic chan_gate(int ch);
			logic [7:0] mix;
			mix = regs[REG_MIXER];
			return (mix[ch] | tone_ph[ch]) & (mix[ch + 3] | noise_lfsr[0]);
		endfunction

		// fixed or envelope amplitude of one channel
		function logic [3:0] chan_level(int ch);
			logic [7:0] amp;
			amp = regs[REG_AMP_A + ch];
			return amp[AMP_ENV_BIT] ? env_lvl : amp[3:0];
		endfunction

		// apply an accepted transaction and queue the result it should give
		function void note_request(psg_req_t r);
			psg_rsp_t e;
			e = '0;
			case (psg_op_t'(r.func))
				OP_LATCH: begin
					addr_latch = r.bus_data;
					n_latch++;
				end
				OP_WRITE: begin
					n_write++;
					if (addr_latch < NUM_REGS) begin
						regs[addr_latch[3:0]] = r.bus_data;
						if (addr_latch[3:0] == REG_SHAPE) begin
							restart_envelope(r.bus_data);
							n_restart++;
						end
					end
				end
				OP_READ: begin
					n_read++;
					e.read_data = (addr_latch < NUM_REGS) ? regs[addr_latch[3:0]] : READ_NONE;
				end
				OP_TICK: begin
					n_tick++;
					clock_generators();
				end
			endcase
			e.chan_a_on    = chan_gate(0);
			e.chan_a_level = chan_level(0);
			e.chan_b_on    = chan_gate(1);
			e.chan_b_level = chan_level(1);
			e.chan_c_on    = chan_gate(2);
			e.chan_c_level = chan_level(2);
			expected_q.push_back(e);
		endfunction

		function bit field_differs(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v === act_v)
				return 1'b0;
			if (n_errors < MAX_REPORTS)
				$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			return 1'b1;
		endfunction

		// compare a result against the oldest outstanding expectation
		function void check_result(psg_rsp_t a);
			psg_rsp_t e;
			bit       bad;
			if (expected_q.size() == 0) begin
				if (n_errors < MAX_REPORTS)
					$error("result %h with no transaction outstanding", a);
				n_errors++;
				return;
			end
			e   = expected_q.pop_front();
			bad = 1'b0;
			n_checked++;
			bad |= field_differs("read_data", e.read_data, a.read_data);
			bad |= field_differs("chan_a_on", 8'(e.chan_a_on), 8'(a.chan_a_on));
			bad |= field_differs("chan_a_level", 8'(e.chan_a_level), 8'(a.chan_a_level));
			bad |= field_differs("chan_b_on", 8'(e.chan_b_on), 8'(a.chan_b_on));
			bad |= field_differs("chan_b_level", 8'(e.chan_b_level), 8'(a.chan_b_level));
			bad |= field_differs("chan_c_on", 8'(e.chan_c_on), 8'(a.chan_c_on));
			bad |= field_differs("chan_c_level", 8'(e.chan_c_level), 8'(a.chan_c_level));
			if (bad)
				n_errors++;
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	psg_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	psg_rsp_t rsp;

	bit idling_on = 1'b1;
	bit calm      = 1'b0;
	int items_sent;

	psg_result_predictor predictor = new();

	psg_tone_noise_envelope_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("psg_tone_noise_envelope_generator regression: fail");
		$finish;
	end

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				predictor.note_request(req);
			if (rsp_valid && !rsp_stall)
				predictor.check_result(rsp);
		end
	end

	// result backpressure in random bursts
	initial begin : result_backpressure
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idling_on && !calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// one transaction, with an optional idle burst ahead of it
	task automatic send_item(psg_op_t op, logic [7:0] data);
		if (idling_on && !calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{func: op, bus_data: data};
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	task automatic write_reg(logic [7:0] addr, logic [7:0] data);
		send_item(OP_LATCH, addr);
		send_item(OP_WRITE, data);
	endtask

	task automatic read_reg(logic [7:0] addr);
		send_item(OP_LATCH, addr);
		send_item(OP_READ, 8'h00);
	endtask

	task automatic tick_run(int n);
		repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// mostly valid addresses, now and then one off the end of the map
	function automatic logic [7:0] pick_address();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(NUM_REGS, 255));
		return 8'($urandom_range(0, NUM_REGS - 1));
	endfunction

	// register values biased towards short periods so the generators turn over often
	function automatic logic [7:0] pick_value(logic [7:0] addr);
		logic [7:0] full;
		full = 8'($urandom_range(0, 255));
		if (addr >= NUM_REGS)
			return full;
		case (addr[3:0])
			REG_TONE_A, 4'(REG_TONE_A + 2), 4'(REG_TONE_A + 4):
				return ($urandom_range(0, 7) == 0) ? full : 8'($urandom_range(0, 12));
			4'(REG_TONE_A + 1), 4'(REG_TONE_A + 3), 4'(REG_TONE_A + 5):
				return ($urandom_range(0, 7) == 0) ? full : 8'h00;
			REG_ENV_FINE:
				return ($urandom_range(0, 7) == 0) ? full : 8'($urandom_range(0, 3));
			REG_ENV_COARSE:
				return ($urandom_range(0, 15) == 0) ? full : 8'h00;
			REG_SHAPE:
				return ($urandom_range(0, 3) == 0) ? full : 8'($urandom_range(0, 15));
			REG_AMP_A, 4'(REG_AMP_A + 1), 4'(REG_AMP_A + 2):
				return {full[7:5], 1'($urandom_range(0, 1)), full[3:0]};
			default:
				return full;
		endcase
	endfunction

	// reset, directed cases, random traffic, drain
	initial begin : stimulus
		int pick;
		logic [7:0] addr;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state and a read of register zero
		send_item(OP_TICK, 8'h00);
		send_item(OP_READ, 8'h00);
		// off-map address: write dropped, read gives all ones
		write_reg(8'hFF, 8'hFF);
		send_item(OP_READ, 8'h00);
		read_reg(8'(NUM_REGS));
		// full bytes at both ends of the map
		write_reg(8'h00, 8'hFF);
		send_item(OP_READ, 8'h00);
		write_reg(8'(NUM_REGS - 1), 8'h5A);
		send_item(OP_READ, 8'h00);
		// all voices enabled, A on the envelope, B fixed at full scale
		write_reg(8'(REG_MIXER), 8'h00);
		write_reg(8'(REG_AMP_A), 8'h1F);
		write_reg(8'(REG_AMP_A + 1), 8'h0F);
		// same shape written twice restarts the envelope both times
		write_reg(8'(REG_SHAPE), 8'h0D);
		send_item(OP_WRITE, 8'h0D);
		tick_run(2);
		write_reg(8'(REG_MIXER), 8'h3F);

		// random sequences: register programming, read-back, tick runs and noise
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				idling_on = !idling_on;
			calm = (items_sent > RANDOM_ITEMS * 85 / 100);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				addr = pick_address();
				write_reg(addr, pick_value(addr));
			end else if (pick < 40) begin
				if ($urandom_range(0, 1))
					send_item(OP_LATCH, pick_address());
				send_item(OP_READ, 8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				tick_run($urandom_range(1, 24));
			end else if (pick < 90) begin
				write_reg(8'(REG_SHAPE), pick_value(8'(REG_SHAPE)));
				tick_run($urandom_range(8, 40));
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(psg_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
		req_valid <= 1'b0;

		// wait for every outstanding result, then a little longer for strays
		@(posedge clk);
		while (predictor.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("exercised %0d latches, %0d writes (%0d envelope restarts), %0d reads, %0d ticks",
			predictor.n_latch, predictor.n_write, predictor.n_restart, predictor.n_read,
			predictor.n_tick);
		$display("%0d results compared, %0d faulty", predictor.n_checked, predictor.n_errors);
		if (predictor.n_errors == 0)
			$display("psg_tone_noise_envelope_generator regression: pass");
		else
			$display("psg_tone_noise_envelope_generator regression: fail");
		$finish;
	end

endmodule
